@@ rtl/gdd_pkg.sv @@
// Shared widths, constants, calendar tables and types for the Gregorian
// date difference block. No dependencies.
package gdd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned YY_W    = 15;   // biased year, up to 16783
  localparam int unsigned PROD_W  = 27;   // year times reciprocal of 100
  localparam int unsigned CENT_W  = 8;    // year / 100, at most 167
  localparam int unsigned MOFF_W  = 9;    // month offset, at most 337
  localparam int unsigned ORD_W   = 23;   // day ordinal
  localparam int unsigned COUNT_W = 22;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register index (paddr bit 2) of include_end_day
  localparam logic REG_INCLUDE_END = 1'b0;

  // Year bias keeps the March-based year unsigned
  localparam logic [YY_W-1:0] YEAR_BIAS = 15'd400;

  // x / 100 == (x * 5243) >> 19 for x below 43690
  localparam logic [PROD_W-1:0] DIV100_MUL   = 27'd5243;
  localparam int unsigned       DIV100_SHIFT = 19;

  localparam logic [YEAR_W-1:0]  CENTURY      = 14'd100;
  localparam logic [ORD_W-1:0]   DAYS_PER_YR  = 23'd365;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [DAY_W-1:0] DAY_LEAP = 5'd29;

  // Per-stage load enables of the ordinal pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Month length in a common year; 0 for month codes outside 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before March-based month mm: (153 * mm + 2) / 5
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MON_W-1:0] mm);
    logic [MOFF_W-1:0] off;
    case (mm)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

@@ rtl/gdd_ordinal.sv @@
// Three-stage pipeline: validity check and day ordinal of one date.
// Depends on gdd_pkg.
module gdd_ordinal
  import gdd_pkg::*;
(
  input  logic              clk_i,
  input  stage_en_t         en_i,
  input  logic [DAY_W-1:0]  day_i,
  input  logic [MON_W-1:0]  month_i,
  input  logic [YEAR_W-1:0] year_i,
  output logic [ORD_W-1:0]  ordinal_o,
  output logic              date_ok_o
);

  // stage 1
  logic [YY_W-1:0]   yy_d, yy_q;
  logic [MON_W-1:0]  mm_d, mm_q;
  logic [DAY_W-1:0]  dm1_d, dm1_q;
  logic [PROD_W-1:0] yy_prod_d, yy_prod_q;
  logic [PROD_W-1:0] y_prod_d, y_prod_q;
  logic [YEAR_W-1:0] year_q;
  logic              day_ok_d, day_ok_q;
  logic              feb29_d, feb29_q;
  logic              early;
  logic [DAY_W-1:0]  len;

  // stage 2
  logic [CENT_W-1:0] cent_d, cent_q;
  logic [CENT_W-1:0] ycent;
  logic              div100, leap;
  logic              ok_d, ok_q;
  logic [ORD_W-1:0]  base_d, base_q;
  logic [MOFF_W-1:0] moff_d, moff_q;
  logic [DAY_W-1:0]  dm1_2_q;

  // stage 3
  logic [ORD_W-1:0]  ord_d, ord_q;
  logic              ok_3_q;

  // Stage 1: March-based year/month, month-length check, /100 products
  always_comb begin
    early     = (month_i <= MON_FEB);
    yy_d      = YY_W'(year_i) + YEAR_BIAS - YY_W'(early);
    mm_d      = early ? (month_i + 4'd9) : (month_i - 4'd3);
    dm1_d     = day_i - 5'd1;
    len       = month_len(month_i);
    day_ok_d  = (day_i != '0) && (day_i <= len);
    feb29_d   = (month_i == MON_FEB) && (day_i == DAY_LEAP);
    yy_prod_d = PROD_W'(yy_d) * DIV100_MUL;
    y_prod_d  = PROD_W'(year_i) * DIV100_MUL;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      yy_q      <= yy_d;
      mm_q      <= mm_d;
      dm1_q     <= dm1_d;
      yy_prod_q <= yy_prod_d;
      y_prod_q  <= y_prod_d;
      year_q    <= year_i;
      day_ok_q  <= day_ok_d;
      feb29_q   <= feb29_d;
    end
  end

  // Stage 2: leap rule, validity, year part of the ordinal
  always_comb begin
    cent_d = yy_prod_q[DIV100_SHIFT +: CENT_W];
    ycent  = y_prod_q[DIV100_SHIFT +: CENT_W];
    div100 = (year_q == (YEAR_W'(ycent) * CENTURY));
    leap   = div100 ? (ycent[1:0] == 2'b00) : (year_q[1:0] == 2'b00);
    ok_d   = day_ok_q || (feb29_q && leap);
    base_d = ORD_W'(yy_q) * DAYS_PER_YR + ORD_W'(yy_q >> 2);
    moff_d = month_offset(mm_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      cent_q  <= cent_d;
      ok_q    <= ok_d;
      base_q  <= base_d;
      moff_q  <= moff_d;
      dm1_2_q <= dm1_q;
    end
  end

  // Stage 3: century terms, month offset, day
  always_comb begin
    ord_d = base_q - ORD_W'(cent_q) + ORD_W'(cent_q >> 2)
          + ORD_W'(moff_q) + ORD_W'(dm1_2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      ord_q  <= ord_d;
      ok_3_q <= ok_q;
    end
  end

  assign ordinal_o = ord_q;
  assign date_ok_o = ok_3_q;

endmodule

@@ rtl/gregorian_date_difference_days.sv @@
// Top level: days between two Gregorian dates, stream in/out, APB config.
// Depends on gdd_pkg and gdd_ordinal.
//
//  channel   | dir | fields (lowest bit first)
//  ----------+-----+------------------------------------------------------
//  s_axis    | in  | tdata: start_day, start_month, start_year,
//            |     |        end_day, end_month, end_year (46 bits, pad 48)
//  m_axis    | out | tdata: day_count (22 bits, pad 24); tuser: status
//  apb       | in  | reg 0 @ 0x0: include_end_day (bit 0)
//
// Four register stages: three in each date's ordinal pipeline (month
// check and /100 products, leap rule and year term, ordinal sum), then
// the output register (difference, include flag, saturation).
// One transaction is taken per cycle when the sink keeps up. Each stage
// holds while the one after it is full and stalled, and empty stages
// fill, so a stall loses or repeats nothing.
// Reset clears the valid bits and include_end_day; payload is not reset.
module gregorian_date_difference_days
  import gdd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [4:0] start_day, [8:5] start_month, [22:9] start_year,
  // [27:23] end_day, [31:28] end_month, [45:32] end_year, [47:46] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [21:0] day_count, [23:22] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] status: 1 when either date is invalid
  output logic                   m_axis_tuser,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  logic              include_end_q;

  logic              v1_q, v2_q, v3_q, v4_q;
  logic              rdy1, rdy2, rdy3, rdy4;
  stage_en_t         en;

  logic [ORD_W-1:0]  ord_start, ord_end;
  logic              ok_start, ok_end;

  logic [ORD_W-1:0]  diff;
  logic [ORD_W:0]    sum;
  logic [COUNT_W-1:0] count_d, count_q;
  logic              status_d, status_q;

  // Config port: always ready, one register at word 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INCLUDE_END) ? PDATA_W'(include_end_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      include_end_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_INCLUDE_END)) begin
      include_end_q <= pwdata[0];
    end
  end

  // Stage k loads when it is empty or its content moves on
  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  gdd_ordinal u_start (
    .clk_i     (clk_i),
    .en_i      (en),
    .day_i     (s_axis_tdata[4:0]),
    .month_i   (s_axis_tdata[8:5]),
    .year_i    (s_axis_tdata[22:9]),
    .ordinal_o (ord_start),
    .date_ok_o (ok_start)
  );

  gdd_ordinal u_end (
    .clk_i     (clk_i),
    .en_i      (en),
    .day_i     (s_axis_tdata[27:23]),
    .month_i   (s_axis_tdata[31:28]),
    .year_i    (s_axis_tdata[45:32]),
    .ordinal_o (ord_end),
    .date_ok_o (ok_end)
  );

  // Output stage: count 0 and status set on an invalid date, else clamp negative span to 0, add flag, saturate
  always_comb begin
    diff = (ord_end > ord_start) ? (ord_end - ord_start) : '0;
    sum  = (ORD_W+1)'(diff) + (ORD_W+1)'(include_end_q);
    if (!(ok_start && ok_end)) begin
      count_d  = '0;
      status_d = 1'b1;
    end else begin
      count_d  = (sum > (ORD_W+1)'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
      status_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = OUT_TDATA_W'(count_q);
  assign m_axis_tuser  = status_q;

endmodule
